### rtl/core/alir_pkg.sv
// shared types and constants of the array list block
`default_nettype none

package alir_pkg;

  localparam int VALUE_W = 32;
  localparam int FUNC_W  = 3;
  localparam int POS_W   = 11;
  localparam int INDEX_W = 10;
  localparam int STAT_W  = 2;

  localparam logic [FUNC_W-1:0] FN_PUSH_TAIL = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POP_TAIL  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PUSH_HEAD = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_HEAD  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD   = 2'd3;

  typedef struct packed {
    logic               ins;
    logic               del;
    logic [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/core/array_list_insert_remove_top.sv
// top level of the bounded array list: request control, cell row, read tree
//
//   channel | handshake              | fields
//   --------+------------------------+------------------------------------------
//   request | in_valid_i / in_ready_o | func_i, value_i, position_i
//   result  | out_valid_o / out_ready_i | removed_value_o, placed_index_o, status_o
//
// push, insert, pop head, refused requests: result registered at the accepting edge,
// where accepted ones shift the cells at and above their position (pop head: all)
// pop tail: tail index registered, result taken from the registered 8-way read tree
// one request in flight; in_ready_o is high while idle and the result slot is free
// or being taken
// reset empties the list at once; cell contents are not cleared
`default_nettype none

module array_list_insert_remove_top #(
  parameter int DEPTH = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic        [alir_pkg::FUNC_W-1:0]  func_i,
  input  wire logic signed [alir_pkg::VALUE_W-1:0] value_i,
  input  wire logic        [alir_pkg::POS_W-1:0]   position_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed      [alir_pkg::VALUE_W-1:0] removed_value_o,
  output logic             [alir_pkg::INDEX_W-1:0] placed_index_o,
  output logic             [alir_pkg::STAT_W-1:0]  status_o
);
  import alir_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam int NL = (AW + 2) / 3;
  localparam int WW = $clog2(NL + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WAIT = 1'b1;

  logic                state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [AW-1:0]       rd_idx_q, rd_idx_d;
  logic [WW-1:0]       wait_q, wait_d;
  logic                out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]  removed_q, removed_d;
  logic [INDEX_W-1:0]  placed_q, placed_d;
  logic [STAT_W-1:0]   status_q, status_d;

  logic                accept;
  logic                full, empty;
  logic                ins, del, go_wait;
  logic [AW-1:0]       ipos;
  logic [VALUE_W-1:0]  res_removed;
  logic [INDEX_W-1:0]  res_placed;
  logic [STAT_W-1:0]   res_status;
  logic [CW-1:0]       res_count;
  cell_cmd_t           cmd;
  logic [VALUE_W-1:0]  cell_data [DEPTH];
  logic [VALUE_W-1:0]  tree_root;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    ins         = 1'b0;
    del         = 1'b0;
    go_wait     = 1'b0;
    ipos        = '0;
    res_removed = '0;
    res_placed  = '0;
    res_status  = STAT_OK;
    res_count   = count_q;
    case (func_i)
      FN_PUSH_TAIL: begin
        if (full) begin
          res_status = STAT_FULL;
        end else begin
          ins        = 1'b1;
          ipos       = AW'(count_q);
          res_placed = INDEX_W'(count_q);
          res_count  = count_q + CW'(1);
        end
      end
      FN_POP_TAIL: begin
        if (empty) begin
          res_status = STAT_EMPTY;
        end else begin
          go_wait   = 1'b1;
          res_count = count_q - CW'(1);
        end
      end
      FN_PUSH_HEAD: begin
        if (full) begin
          res_status = STAT_FULL;
        end else begin
          ins       = 1'b1;
          res_count = count_q + CW'(1);
        end
      end
      FN_POP_HEAD: begin
        if (empty) begin
          res_status = STAT_EMPTY;
        end else begin
          del         = 1'b1;
          res_removed = cell_data[0];
          res_count   = count_q - CW'(1);
        end
      end
      FN_INSERT: begin
        if (full) begin
          res_status = STAT_FULL;
        end else if (XW'(position_i) > XW'(count_q)) begin
          res_status = STAT_BAD;
        end else begin
          ins        = 1'b1;
          ipos       = AW'(position_i);
          res_placed = INDEX_W'(position_i);
          res_count  = count_q + CW'(1);
        end
      end
      default: begin
        res_status = STAT_BAD;
      end
    endcase
  end

  assign cmd.ins   = accept && ins;
  assign cmd.del   = accept && del;
  assign cmd.value = value_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    wait_d      = wait_q;
    out_valid_d = out_valid_q && !out_ready_i;
    removed_d   = removed_q;
    placed_d    = placed_q;
    status_d    = status_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          count_d = res_count;
          if (go_wait) begin
            state_d  = S_WAIT;
            rd_idx_d = AW'(count_q - CW'(1));
            wait_d   = WW'(NL);
          end else begin
            out_valid_d = 1'b1;
            removed_d   = res_removed;
            placed_d    = res_placed;
            status_d    = res_status;
          end
        end
      end
      S_WAIT: begin
        if (wait_q == '0) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          removed_d   = tree_root;
          placed_d    = '0;
          status_d    = STAT_OK;
        end else begin
          wait_d = wait_q - WW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wait_q      <= wait_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    removed_q <= removed_d;
    placed_q  <= placed_d;
    status_q  <= status_d;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] left;
    logic [VALUE_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    alir_cell #(
      .AW  (AW),
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (ipos),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

  alir_tree #(
    .DEPTH (DEPTH)
  ) u_tree (
    .clk_i   (clk_i),
    .idx_i   (rd_idx_q),
    .cells_i (cell_data),
    .root_o  (tree_root)
  );

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign placed_index_o  = placed_q;
  assign status_o        = status_q;

`ifndef SYNTHESIS
  a_wait_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT) |-> !out_valid_q)
    else $error("result slot busy while reading tail");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_valid_q || state_q == S_WAIT))
    else $error("request accepted without result under way");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("count moved without a request");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("count beyond depth");
`endif

endmodule

`default_nettype wire

### rtl/core/alir_cell.sv
// one list cell: holds a word, loads, shifts up from the left or down from the right
`default_nettype none

module alir_cell #(
  parameter int AW  = 10,
  parameter int IDX = 0
) (
  input  wire logic                          clk_i,
  input  wire alir_pkg::cell_cmd_t           cmd_i,
  input  wire logic [AW-1:0]                 pos_i,
  input  wire logic [alir_pkg::VALUE_W-1:0]  left_i,
  input  wire logic [alir_pkg::VALUE_W-1:0]  right_i,
  output logic      [alir_pkg::VALUE_W-1:0]  data_o
);
  import alir_pkg::*;

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  logic [VALUE_W-1:0] data_q;
  logic [VALUE_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (MY_IDX == pos_i) begin
        data_d = cmd_i.value;
      end else if (MY_IDX > pos_i) begin
        data_d = left_i;
      end
    end else if (cmd_i.del) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

### rtl/core/alir_tree.sv
// registered 8-way read tree that picks one cell by index
`default_nettype none

module alir_tree #(
  parameter int DEPTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic [$clog2(DEPTH)-1:0]      idx_i,
  input  wire logic [alir_pkg::VALUE_W-1:0]  cells_i [DEPTH],
  output logic      [alir_pkg::VALUE_W-1:0]  root_o
);
  import alir_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int NL = (AW + 2) / 3;
  localparam int SW = 3 * NL;
  localparam int NP = 1 << SW;

  function automatic int node_off(input int k);
    int acc;
    acc = 0;
    for (int m = 1; m < k; m++) begin
      acc = acc + (NP >> (3 * m));
    end
    return acc;
  endfunction

  localparam int NN = node_off(NL + 1);

  logic [SW-1:0]      sel;
  logic [VALUE_W-1:0] leaf   [NP];
  logic [VALUE_W-1:0] node_d [NN];
  logic [VALUE_W-1:0] node_q [NN];

  assign sel = SW'(idx_i);

  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < DEPTH) begin : g_real
      assign leaf[i] = cells_i[i];
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  for (genvar k = 1; k <= NL; k++) begin : g_lvl
    for (genvar j = 0; j < (NP >> (3 * k)); j++) begin : g_node
      logic [VALUE_W-1:0] kid [8];
      for (genvar d = 0; d < 8; d++) begin : g_kid
        if (k == 1) begin : g_from_leaf
          assign kid[d] = leaf[8 * j + d];
        end else begin : g_from_node
          assign kid[d] = node_q[node_off(k - 1) + 8 * j + d];
        end
      end
      assign node_d[node_off(k) + j] = kid[sel[3*(k-1) +: 3]];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int n = 0; n < NN; n++) begin
      node_q[n] <= node_d[n];
    end
  end

  assign root_o = node_q[node_off(NL)];

endmodule

`default_nettype wire

### dv/array_list_insert_remove_top_tb.sv
// self-checking testbench of the bounded array list with positional insert
`timescale 1ns / 100ps

module array_list_insert_remove_top_tb;
  import alir_pkg::*;

  localparam int LIST_DEPTH   = 1024;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASE_ITEMS  = 150;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed;
    logic [INDEX_W-1:0]        slot;
    logic [STAT_W-1:0]         code;
  } list_result_t;

  class list_scoreboard;
    logic [VALUE_W-1:0] words [LIST_DEPTH];
    int unsigned        fill;
    list_result_t       pending [$];
    int                 errors;

    function void open_gap(int unsigned pos, logic [VALUE_W-1:0] word);
      for (int unsigned i = fill; i > pos; i--) begin
        words[i] = words[i-1];
      end
      words[pos] = word;
      fill++;
    endfunction

    function void note_request(logic [FUNC_W-1:0] fn, logic signed [VALUE_W-1:0] word,
                               logic [POS_W-1:0] pos);
      list_result_t r;
      r = '0;
      r.code = STAT_OK;
      case (fn)
        FN_PUSH_TAIL: begin
          if (fill == LIST_DEPTH) r.code = STAT_FULL;
          else begin
            r.slot = fill[INDEX_W-1:0];
            open_gap(fill, word);
          end
        end
        FN_POP_TAIL: begin
          if (fill == 0) r.code = STAT_EMPTY;
          else begin
            fill--;
            r.removed = words[fill];
          end
        end
        FN_PUSH_HEAD: begin
          if (fill == LIST_DEPTH) r.code = STAT_FULL;
          else open_gap(0, word);
        end
        FN_POP_HEAD: begin
          if (fill == 0) r.code = STAT_EMPTY;
          else begin
            r.removed = words[0];
            fill--;
            for (int unsigned i = 0; i < fill; i++) begin
              words[i] = words[i+1];
            end
          end
        end
        FN_INSERT: begin
          if (fill == LIST_DEPTH) r.code = STAT_FULL;
          else if (pos > fill) r.code = STAT_BAD;
          else begin
            r.slot = pos[INDEX_W-1:0];
            open_gap(pos, word);
          end
        end
        default: r.code = STAT_BAD;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [VALUE_W-1:0] removed, logic [INDEX_W-1:0] slot,
                               logic [STAT_W-1:0] code);
      list_result_t want;
      if (pending.size() == 0) begin
        $error("result with no request waiting: removed_value %0d placed_index %0d status %0d",
               removed, slot, code);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (removed !== want.removed) begin
        $error("removed_value: expected %0d, actual %0d", want.removed, removed);
        errors++;
      end
      if (slot !== want.slot) begin
        $error("placed_index: expected %0d, actual %0d", want.slot, slot);
        errors++;
      end
      if (code !== want.code) begin
        $error("status: expected %0d, actual %0d", want.code, code);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [FUNC_W-1:0]         func_i;
  logic signed [VALUE_W-1:0] value_i;
  logic [POS_W-1:0]          position_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [VALUE_W-1:0] removed_value_o;
  logic [INDEX_W-1:0]        placed_index_o;
  logic [STAT_W-1:0]         status_o;

  list_scoreboard board = new();
  int send_idle_pct;
  int recv_stall_pct;

  array_list_insert_remove_top #(.DEPTH(LIST_DEPTH)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .removed_value_o(removed_value_o),
    .placed_index_o (placed_index_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("array_list_insert_remove_top_tb: FAIL");
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_result(removed_value_o, placed_index_o, status_o);
    end
  end

  function automatic void set_idle_phase(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default: begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_request(logic [FUNC_W-1:0] fn, logic signed [VALUE_W-1:0] word,
                              logic [POS_W-1:0] pos);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    value_i    <= word;
    position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(fn, word, pos);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (board.pending.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] random_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(bit filling, output bit known);
    int r;
    logic [FUNC_W-1:0] fn;
    logic [POS_W-1:0]  pos;
    r     = $urandom_range(99);
    pos   = POS_W'($urandom_range(board.fill));
    known = 1'b1;
    if (r < 2) begin
      fn    = FUNC_W'($urandom_range(7, 5));
      pos   = POS_W'($urandom);
      known = 1'b0;
    end else if (r < 5) begin
      fn  = FN_INSERT;
      pos = POS_W'($urandom_range(2047, board.fill + 1));
    end else if (filling) begin
      if (r < 35)      fn = FN_PUSH_TAIL;
      else if (r < 60) fn = FN_PUSH_HEAD;
      else if (r < 96) fn = FN_INSERT;
      else if (r < 98) fn = FN_POP_TAIL;
      else             fn = FN_POP_HEAD;
    end else begin
      if (r < 48)      fn = FN_POP_TAIL;
      else if (r < 88) fn = FN_POP_HEAD;
      else if (r < 93) fn = FN_PUSH_TAIL;
      else if (r < 96) fn = FN_PUSH_HEAD;
      else             fn = FN_INSERT;
    end
    send_request(fn, random_word(), pos);
  endtask

  initial begin
    int  sent;
    int  full_hold;
    int  phase;
    bit  filling;
    bit  seen_full;
    bit  known;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    func_i     = '0;
    value_i    = '0;
    position_i = '0;
    set_idle_phase(0);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty list, bad positions, unknown codes, every operation at the edges
    send_request(FN_POP_TAIL, 0, 0);
    send_request(FN_POP_HEAD, 0, 0);
    send_request(FN_INSERT, 32'h1234_5678, 1);
    send_request(FN_INSERT, 32'h8000_0000, 0);
    send_request(FN_PUSH_TAIL, 32'h7fff_ffff, 11'h7ff);
    send_request(FN_PUSH_HEAD, -1, 11'h7ff);
    send_request(FN_INSERT, 0, 3);
    send_request(FN_INSERT, 32'h5555_5555, 1);
    send_request(FN_INSERT, -1, 11'h7ff);
    send_request(FN_INSERT, -1, 11'd1024);
    send_request(FN_INSERT, 32'haaaa_aaaa, 6);
    send_request(3'd5, -1, 11'h7ff);
    send_request(3'd6, 0, 0);
    send_request(3'd7, 32'h8000_0000, 11'h400);
    send_request(FN_POP_HEAD, 0, 0);
    send_request(FN_POP_TAIL, 0, 0);
    send_request(FN_INSERT, 32'h0000_0001, 4);
    send_request(FN_POP_HEAD, 0, 0);
    send_request(FN_POP_TAIL, 0, 0);
    send_request(FN_POP_HEAD, 0, 0);
    send_request(FN_POP_TAIL, 0, 0);
    send_request(FN_POP_HEAD, 0, 0);
    send_request(FN_POP_TAIL, 0, 0);
    drain_results();

    // random part: fill to full, hold there, drain back to empty
    sent      = 0;
    full_hold = 0;
    phase     = 0;
    filling   = 1'b1;
    seen_full = 1'b0;
    while (sent < RANDOM_ITEMS || !seen_full) begin
      if (board.fill == LIST_DEPTH) begin
        seen_full = 1'b1;
        full_hold++;
        if (full_hold > 12) filling = 1'b0;
      end else if (board.fill == 0 && !filling) begin
        filling   = 1'b1;
        full_hold = 0;
      end
      send_random(filling, known);
      if (known) begin
        sent++;
        if (sent % PHASE_ITEMS == 0) begin
          phase++;
          drain_results();
          set_idle_phase(phase);
        end
      end
    end
    in_valid_i <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("array_list_insert_remove_top_tb: PASS");
    end else begin
      $display("array_list_insert_remove_top_tb: FAIL");
    end
    $finish;
  end

endmodule
